FILE: rtl/psps_pkg.sv
// Shared types and constants of the paced sensor poll sequencer.
package psps_pkg;

  localparam int unsigned DELAY_W = 16;
  localparam int unsigned TRIES_W = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NOW_W   = 32;
  localparam int unsigned IDX_W   = 2;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_PREP = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [1:0] PH_CODE_IDLE     = 2'd0;
  localparam logic [1:0] PH_CODE_PREPARED = 2'd1;
  localparam logic [1:0] PH_CODE_WAIT     = 2'd2;
  localparam logic [1:0] PH_CODE_READ     = 2'd3;

  localparam logic [BYTE_W-1:0] ST_OK     = 8'h00;
  localparam logic [BYTE_W-1:0] ST_BUSY   = 8'hFE;
  localparam logic [BYTE_W-1:0] TEMP_NONE = 8'hFF;

  localparam logic [DELAY_W-1:0] PREP_DELAY_RST  = 16'd60;
  localparam logic [DELAY_W-1:0] RETRY_DELAY_RST = 16'd100;
  localparam logic [TRIES_W-1:0] MAX_RETRIES_RST = 4'd3;
  localparam logic [DELAY_W-1:0] MIN_PERIOD_RST  = 16'd1000;

  localparam logic [IDX_W-1:0] REG_PREP_DELAY  = 2'd0;
  localparam logic [IDX_W-1:0] REG_RETRY_DELAY = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_RETRIES = 2'd2;
  localparam logic [IDX_W-1:0] REG_MIN_PERIOD  = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_PREPARED = 4'b0010,
    PH_WAIT     = 4'b0100,
    PH_READ     = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [DELAY_W-1:0] min_period_ms;
    logic [TRIES_W-1:0] max_retries;
    logic [DELAY_W-1:0] retry_delay_ms;
    logic [DELAY_W-1:0] prep_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] temperature_byte;
    logic [BYTE_W-1:0] status_byte;
    logic              read_acked;
    logic              prepare_acked;
    logic [NOW_W-1:0]  now_ms;
  } step_in_t;

  typedef struct packed {
    logic [1:0]        phase;
    logic [BYTE_W-1:0] temperature;
    logic              reading_valid;
    logic [1:0]        bus_action;
  } step_res_t;

  function automatic logic [1:0] phase_code(phase_t ph);
    logic [1:0] code;
    code = PH_CODE_IDLE;
    unique case (ph)
      PH_IDLE:     code = PH_CODE_IDLE;
      PH_PREPARED: code = PH_CODE_PREPARED;
      PH_WAIT:     code = PH_CODE_WAIT;
      PH_READ:     code = PH_CODE_READ;
      default:     code = PH_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/psps_cfg.sv
// Configuration register file of the poll sequencer.
module psps_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [psps_pkg::IDX_W-1:0] cfg_index,
  input  logic [psps_pkg::DELAY_W-1:0] cfg_data,
  output psps_pkg::cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prep_delay_ms  <= psps_pkg::PREP_DELAY_RST;
      cfg.retry_delay_ms <= psps_pkg::RETRY_DELAY_RST;
      cfg.max_retries    <= psps_pkg::MAX_RETRIES_RST;
      cfg.min_period_ms  <= psps_pkg::MIN_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psps_pkg::REG_PREP_DELAY:  cfg.prep_delay_ms  <= cfg_data;
        psps_pkg::REG_RETRY_DELAY: cfg.retry_delay_ms <= cfg_data;
        psps_pkg::REG_MAX_RETRIES:
          cfg.max_retries <= cfg_data[psps_pkg::TRIES_W-1:0];
        psps_pkg::REG_MIN_PERIOD:  cfg.min_period_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/psps_step.sv
// Poll step logic: sequencer state and its next-state rules.
module psps_step #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step_en,
  input  psps_pkg::step_in_t  item,
  input  psps_pkg::cfg_t      cfg,
  output psps_pkg::step_res_t res
);

  psps_pkg::phase_t             phase, phase_next;
  logic [TIME_BITS-1:0]         deadline, deadline_next;
  logic [TIME_BITS-1:0]         next_period, next_period_next;
  logic [psps_pkg::TRIES_W-1:0] retries_left, retries_left_next;
  logic                         valid_flag, valid_flag_next;
  logic [psps_pkg::BYTE_W-1:0]  stored_temp, stored_temp_next;
  logic [1:0]                   action;

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] period_diff;
  logic [TIME_BITS-1:0] deadline_diff;
  logic [TIME_BITS-1:0] now_plus_prep;
  logic [TIME_BITS-1:0] now_plus_retry;
  logic [TIME_BITS-1:0] now_plus_period;
  logic                 read_ok;
  logic                 read_busy;

  assign now             = TIME_BITS'(item.now_ms);
  assign period_diff     = now - next_period;
  assign deadline_diff   = now - deadline;
  assign now_plus_prep   = now + TIME_BITS'(cfg.prep_delay_ms);
  assign now_plus_retry  = now + TIME_BITS'(cfg.retry_delay_ms);
  assign now_plus_period = now + TIME_BITS'(cfg.min_period_ms);
  assign read_ok   = item.read_acked && (item.status_byte == psps_pkg::ST_OK);
  assign read_busy = item.read_acked && (item.status_byte == psps_pkg::ST_BUSY);

  always_comb begin
    phase_next        = phase;
    deadline_next     = deadline;
    next_period_next  = next_period;
    retries_left_next = retries_left;
    valid_flag_next   = valid_flag;
    stored_temp_next  = stored_temp;
    action            = psps_pkg::ACT_NONE;
    if (!period_diff[TIME_BITS-1]) begin
      unique case (phase)
        psps_pkg::PH_IDLE: begin
          action = psps_pkg::ACT_PREP;
          if (item.prepare_acked) begin
            phase_next = psps_pkg::PH_PREPARED;
          end else begin
            valid_flag_next  = 1'b0;
            stored_temp_next = psps_pkg::TEMP_NONE;
            deadline_next    = now_plus_retry;
            phase_next       = psps_pkg::PH_WAIT;
          end
        end
        psps_pkg::PH_PREPARED: begin
          retries_left_next = cfg.max_retries;
          deadline_next     = now_plus_prep;
          phase_next        = psps_pkg::PH_WAIT;
        end
        psps_pkg::PH_WAIT: begin
          if (!deadline_diff[TIME_BITS-1]) begin
            phase_next = psps_pkg::PH_READ;
          end
        end
        psps_pkg::PH_READ: begin
          action = psps_pkg::ACT_READ;
          priority if (read_ok) begin
            valid_flag_next  = 1'b1;
            stored_temp_next = item.temperature_byte;
            phase_next       = psps_pkg::PH_IDLE;
            next_period_next = now_plus_period;
          end else if (read_busy && (retries_left != '0)) begin
            retries_left_next = retries_left - 1'b1;
            deadline_next     = now_plus_retry;
            phase_next        = psps_pkg::PH_WAIT;
          end else begin
            valid_flag_next  = 1'b0;
            phase_next       = psps_pkg::PH_IDLE;
            next_period_next = now_plus_period;
          end
        end
        default: phase_next = psps_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= psps_pkg::PH_IDLE;
      deadline     <= '0;
      next_period  <= '0;
      retries_left <= psps_pkg::MAX_RETRIES_RST;
      valid_flag   <= 1'b0;
      stored_temp  <= psps_pkg::TEMP_NONE;
    end else if (step_en) begin
      phase        <= phase_next;
      deadline     <= deadline_next;
      next_period  <= next_period_next;
      retries_left <= retries_left_next;
      valid_flag   <= valid_flag_next;
      stored_temp  <= stored_temp_next;
    end
  end

  assign res.bus_action    = action;
  assign res.reading_valid = valid_flag_next;
  assign res.temperature   = stored_temp_next;
  assign res.phase         = psps_pkg::phase_code(phase_next);

endmodule

FILE: rtl/paced_sensor_poll_sequencer.sv
// Top level of the paced sensor poll sequencer: input and result registers.
// One poll step per word; a step passes the step logic between the input
// register and the result register, so a new word is taken every clock while
// the result side keeps up. The result word is registered in the result
// register and offered on the master side. The sequencer state (phase,
// deadline, retry count, hold-off time) is updated when a word passes the step
// logic, so back-to-back words see each other's effect in order. Configuration
// writes take effect on the next step.
module paced_sensor_poll_sequencer #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // now_ms[31:0], prepare_acked[32], read_acked[33], status_byte[41:34],
  // temperature_byte[49:42], zero fill [55:50]
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // bus_action[1:0], reading_valid[2], temperature[10:3], phase[12:11],
  // zero fill [15:13]
  output logic [15:0] m_tdata,
  input  logic        cfg_we,
  input  logic [psps_pkg::IDX_W-1:0]   cfg_index,
  input  logic [psps_pkg::DELAY_W-1:0] cfg_data
);

  localparam int unsigned IN_W  = $bits(psps_pkg::step_in_t);
  localparam int unsigned RES_W = $bits(psps_pkg::step_res_t);

  psps_pkg::cfg_t      cfg;
  psps_pkg::step_in_t  in_word;
  psps_pkg::step_res_t res;
  psps_pkg::step_res_t out_word;
  logic                in_vld;
  logic                advance;
  logic                step_en;

  assign advance  = !m_tvalid || m_tready;
  assign step_en  = in_vld && advance;
  assign s_tready = !in_vld || advance;

  psps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  psps_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .item    (in_word),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_word <= s_tdata[IN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_word <= res;
    end
  end

  assign m_tdata = {{(16 - RES_W){1'b0}}, out_word};

  a_in_loaded: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_vld)
    else $error("accepted word not held in input register");

  a_step_to_out: assert property (@(posedge clk) disable iff (rst)
    step_en |=> m_tvalid)
    else $error("stepped word did not reach result register");

  a_prep_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_word.bus_action == psps_pkg::ACT_PREP) |->
      (out_word.phase == psps_pkg::PH_CODE_PREPARED) ||
      (out_word.phase == psps_pkg::PH_CODE_WAIT))
    else $error("prepare step left an unexpected phase");

  a_read_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_word.bus_action == psps_pkg::ACT_READ) |->
      (out_word.phase == psps_pkg::PH_CODE_IDLE) ||
      (out_word.phase == psps_pkg::PH_CODE_WAIT))
    else $error("read step left an unexpected phase");

endmodule
